// ----- hw/rtl/rbsi_pkg.sv -----
// Shared widths, constants and types for the ray versus box slab test.
package rbsi_pkg;

   // Slab numerator (+-half - origin), signed Q18.16.
   localparam int NUM_W   = 34;
   // Ray direction component, signed Q16.16.
   localparam int DEN_W   = 32;
   // Magnitude of a slab numerator.
   localparam int NMAG_W  = 33;
   // Fraction bits appended to the numerator before the divide.
   localparam int FRAC_W  = 16;
   // Quotient magnitude bits, one per divider stage.
   localparam int QMAG_W  = NMAG_W + FRAC_W;
   // Divider remainder width (remainder stays below the divisor magnitude).
   localparam int REM_W   = DEN_W;
   // Signed width of a crossing parameter, with room for the unbounded marks.
   localparam int T_W     = 52;
   // Divider latency: magnitude stage, one stage per quotient bit, sign fix.
   localparam int DIV_LAT = QMAG_W + 2;

   typedef logic signed [T_W-1:0] tparam_type;

   localparam tparam_type T_POS_UNBOUNDED = tparam_type'(64'sd1 <<< 50);
   localparam tparam_type T_NEG_UNBOUNDED = -(tparam_type'(64'sd1 <<< 50));
   localparam tparam_type T_SAT_MAX       = tparam_type'(64'sd2147483647);
   localparam tparam_type T_SAT_MIN       = tparam_type'(-64'sd2147483648);

   // Per-item side information that travels next to the divider pipeline.
   typedef struct packed {
      logic       valid;
      logic [2:0] parallel;
      logic [2:0] dir_neg;
      logic       par_miss;
   } side_type;

endpackage

// ----- hw/rtl/rbsi_div.sv -----
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per stage.
module rbsi_div
   import rbsi_pkg::*;
(
   input  logic                    clock,
   input  logic                    enable,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DEN_W-1:0] den,
   output tparam_type              quot
);

   logic [QMAG_W-1:0] dvd_ff  [0:QMAG_W];
   logic [DEN_W-1:0]  dmag_ff [0:QMAG_W];
   logic [REM_W-1:0]  rem_ff  [0:QMAG_W];
   logic [QMAG_W-1:0] quo_ff  [0:QMAG_W];
   logic              neg_ff  [0:QMAG_W];
   logic [NMAG_W-1:0] nmag_in;
   logic [DEN_W-1:0]  dmag_in;
   tparam_type        quot_ff;
   tparam_type        quot_in;

   // Magnitudes and the sign of the true quotient.
   always_comb begin
      nmag_in = num[NUM_W-1] ? NMAG_W'(-num) : NMAG_W'(num);
      dmag_in = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dvd_ff[0]  <= {nmag_in, FRAC_W'(0)};
         dmag_ff[0] <= dmag_in;
         rem_ff[0]  <= '0;
         quo_ff[0]  <= '0;
         neg_ff[0]  <= num[NUM_W-1] ^ den[DEN_W-1];
      end
   end

   // One subtract-and-compare per stage, most significant quotient bit first.
   for (genvar i = 0; i < QMAG_W; i++) begin : g_stage
      logic [REM_W:0] shifted;
      logic [REM_W:0] dext;
      logic           ge;
      logic [REM_W:0] diff;

      always_comb begin
         shifted = {rem_ff[i], dvd_ff[i][QMAG_W-1-i]};
         dext    = {1'b0, dmag_ff[i]};
         ge      = (shifted >= dext);
         diff    = shifted - dext;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dvd_ff[i+1]  <= dvd_ff[i];
            dmag_ff[i+1] <= dmag_ff[i];
            rem_ff[i+1]  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            quo_ff[i+1]  <= {quo_ff[i][QMAG_W-2:0], ge};
            neg_ff[i+1]  <= neg_ff[i];
         end
      end
   end

   // Apply the sign; a negative quotient with a remainder rounds down once more.
   always_comb begin
      quot_in = tparam_type'({3'b000, quo_ff[QMAG_W]});
      if (neg_ff[QMAG_W]) begin
         quot_in = -quot_in - ((rem_ff[QMAG_W] != '0) ? tparam_type'(1) : tparam_type'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

// ----- hw/rtl/rbsi_merge.sv -----
// Interval merge: folds the three slab intervals into one entry/exit pair and picks the result.
module rbsi_merge
   import rbsi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  side_type          side,
   input  tparam_type        q_lo [0:2],
   input  tparam_type        q_hi [0:2],
   output logic              out_valid,
   output logic              out_hit,
   output logic signed [31:0] out_param
);

   tparam_type lo [0:2];
   tparam_type hi [0:2];
   tparam_type enter_xy_in, exit_xy_in;
   tparam_type enter_xy_ff, exit_xy_ff, lo_z_ff, hi_z_ff;
   logic       valid_m1_ff, miss_m1_ff;
   tparam_type enter_in, exit_in;
   tparam_type enter_ff, exit_ff;
   logic       valid_m2_ff, miss_m2_ff;
   logic       miss;
   tparam_type t_sel;
   logic signed [31:0] param_in;
   logic       valid_ff;
   logic       hit_ff;
   logic signed [31:0] param_ff;

   // Per-axis interval; a parallel axis leaves the interval unbounded.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (side.parallel[a]) begin
            lo[a] = T_NEG_UNBOUNDED;
            hi[a] = T_POS_UNBOUNDED;
         end else if (side.dir_neg[a]) begin
            lo[a] = q_hi[a];
            hi[a] = q_lo[a];
         end else begin
            lo[a] = q_lo[a];
            hi[a] = q_hi[a];
         end
      end
      enter_xy_in = (lo[0] > lo[1]) ? lo[0] : lo[1];
      exit_xy_in  = (hi[0] < hi[1]) ? hi[0] : hi[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_m1_ff <= 1'b0;
      end else if (enable) begin
         valid_m1_ff <= side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         enter_xy_ff <= enter_xy_in;
         exit_xy_ff  <= exit_xy_in;
         lo_z_ff     <= lo[2];
         hi_z_ff     <= hi[2];
         miss_m1_ff  <= side.par_miss;
      end
   end

   // Fold in the z axis.
   always_comb begin
      enter_in = (enter_xy_ff > lo_z_ff) ? enter_xy_ff : lo_z_ff;
      exit_in  = (exit_xy_ff < hi_z_ff) ? exit_xy_ff : hi_z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_m2_ff <= 1'b0;
      end else if (enable) begin
         valid_m2_ff <= valid_m1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         enter_ff   <= enter_in;
         exit_ff    <= exit_in;
         miss_m2_ff <= miss_m1_ff;
      end
   end

   // Empty interval or a box behind the origin is a miss; otherwise saturate.
   always_comb begin
      miss  = miss_m2_ff || (enter_ff > exit_ff) || exit_ff[T_W-1];
      t_sel = enter_ff[T_W-1] ? exit_ff : enter_ff;
      if (t_sel > T_SAT_MAX) begin
         param_in = 32'sh7FFFFFFF;
      end else if (t_sel < T_SAT_MIN) begin
         param_in = 32'sh80000000;
      end else begin
         param_in = t_sel[31:0];
      end
      if (miss) begin
         param_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_m2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hit_ff   <= !miss;
         param_ff <= param_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;
   assign out_param = param_ff;

endmodule

// ----- hw/rtl/ray_box_slab_intersect.sv -----
// Top level of the pipelined ray versus origin-centered box slab test.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  origin_x/y/z, dir_x/y/z, half_x/y/z
//   rsp_      out        rsp_valid / rsp_stall  hit, ray_param
//
// One ray enters per cycle while req_stall is low; a ray passes the input stage,
// the divider, two merge stages and the output register. The divider depth, one quotient bit
// per stage over 49 bits, sets the latency. Reset clears the valid bits and the
// side information; the data registers are not reset.
// When a result waits with rsp_stall high the whole pipeline holds, and req_stall
// is raised for exactly those cycles.
module ray_box_slab_intersect
   import rbsi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic        [30:0] req_half_x,
   input  logic        [30:0] req_half_y,
   input  logic        [30:0] req_half_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_ray_param
);

   logic                    advance;
   logic signed [31:0]      org [0:2];
   logic signed [31:0]      dir [0:2];
   logic [30:0]             half [0:2];
   logic signed [NUM_W-1:0] lo_num_in [0:2];
   logic signed [NUM_W-1:0] hi_num_in [0:2];
   logic signed [NUM_W-1:0] lo_num_ff [0:2];
   logic signed [NUM_W-1:0] hi_num_ff [0:2];
   logic signed [DEN_W-1:0] dir_ff [0:2];
   side_type                side_in;
   side_type                side_ff [0:DIV_LAT];
   tparam_type              q_lo [0:2];
   tparam_type              q_hi [0:2];

   // The pipeline moves unless a finished result is held at the output.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      org[0]  = req_origin_x;  org[1]  = req_origin_y;  org[2]  = req_origin_z;
      dir[0]  = req_dir_x;     dir[1]  = req_dir_y;     dir[2]  = req_dir_z;
      half[0] = req_half_x;    half[1] = req_half_y;    half[2] = req_half_z;
   end

   // Slab numerators and parallel-axis checks.
   always_comb begin
      side_in.valid    = req_valid;
      side_in.par_miss = 1'b0;
      for (int a = 0; a < 3; a++) begin
         lo_num_in[a] = -$signed({3'b000, half[a]}) - NUM_W'(org[a]);
         hi_num_in[a] = $signed({3'b000, half[a]}) - NUM_W'(org[a]);
         side_in.parallel[a] = (dir[a] == '0);
         side_in.dir_neg[a]  = dir[a][31];
         if (side_in.parallel[a] && (hi_num_in[a] < 0 || lo_num_in[a] > 0)) begin
            side_in.par_miss = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            lo_num_ff[a] <= lo_num_in[a];
            hi_num_ff[a] <= hi_num_in[a];
            dir_ff[a]    <= dir[a];
         end
      end
   end

   // Side information delay line, matched to the divider latency.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_LAT; s++) begin
            side_ff[s] <= '0;
         end
      end else if (advance) begin
         side_ff[0] <= side_in;
         for (int s = 1; s <= DIV_LAT; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // Two crossing dividers per axis.
   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbsi_div u_div_lo (
         .clock  (clock),
         .enable (advance),
         .num    (lo_num_ff[a]),
         .den    (dir_ff[a]),
         .quot   (q_lo[a])
      );
      rbsi_div u_div_hi (
         .clock  (clock),
         .enable (advance),
         .num    (hi_num_ff[a]),
         .den    (dir_ff[a]),
         .quot   (q_hi[a])
      );
   end

   rbsi_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .side      (side_ff[DIV_LAT]),
      .q_lo      (q_lo),
      .q_hi      (q_hi),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_param (rsp_ray_param)
   );

   // A miss always reports a zero parameter.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_ray_param == '0)
      else $error("miss with nonzero ray parameter");

   // A hit never lies behind the origin.
   a_hit_ahead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_ray_param[31])
      else $error("hit with negative ray parameter");

   // A held result keeps the whole pipeline frozen for the next edge.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(side_ff[DIV_LAT].valid))
      else $error("pipeline moved while the output was held");

endmodule

// ----- tb/ray_box_slab_intersect_checker.sv -----
// Checker that predicts and compares every ray versus box result transfer.
`timescale 1ns / 100ps
module ray_box_slab_intersect_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic        [30:0] req_half_x,
   input  logic        [30:0] req_half_y,
   input  logic        [30:0] req_half_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_hit,
   input  logic signed [31:0] rsp_ray_param,
   output int                 fail_count,
   output int                 pending_count,
   output int                 hit_count
);

   typedef struct packed {
      logic               hit;
      logic signed [31:0] ray_param;
   } slab_result_type;

   slab_result_type hit_queue[$];

   // Floor of num * 2^16 / den, computed exactly at 64 bits.
   function automatic longint floor_div_q16(longint num, longint den);
      longint n;
      longint d;
      longint q;
      n = num * 65536;
      d = den;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   // Three-axis slab test predicting hit and the saturated ray parameter.
   function automatic slab_result_type slab_test(longint o[3], longint d[3], longint h[3]);
      longint t_enter;
      longint t_exit;
      longint lo;
      longint hi;
      longint swap;
      longint t;
      bit miss;
      slab_result_type r;
      t_enter = -(64'sd1 <<< 62);
      t_exit = 64'sd1 <<< 62;
      miss = 0;
      for (int a = 0; a < 3; a++) begin
         if (!miss) begin
            if (d[a] == 0) begin
               // Parallel axis: the origin must lie within the slab.
               if (o[a] < -h[a] || o[a] > h[a]) miss = 1;
            end else begin
               lo = floor_div_q16(-h[a] - o[a], d[a]);
               hi = floor_div_q16(h[a] - o[a], d[a]);
               if (d[a] < 0) begin
                  swap = lo;
                  lo = hi;
                  hi = swap;
               end
               if (lo > t_enter) t_enter = lo;
               if (hi < t_exit) t_exit = hi;
               if (t_enter > t_exit) miss = 1;
            end
         end
      end
      if (!miss && t_exit < 0) miss = 1;
      if (miss) begin
         r.hit = 0;
         r.ray_param = 0;
      end else begin
         t = (t_enter >= 0) ? t_enter : t_exit;
         if (t > 64'sd2147483647) t = 64'sd2147483647;
         if (t < -64'sd2147483648) t = -64'sd2147483648;
         r.hit = 1;
         r.ray_param = t[31:0];
      end
      return r;
   endfunction

   assign pending_count = hit_queue.size();

   // Predict on each request transfer and compare on each result transfer.
   always @(posedge clock) begin
      longint o[3];
      longint d[3];
      longint h[3];
      slab_result_type want;
      if (reset) begin
         fail_count <= 0;
         hit_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            o[0] = req_origin_x; o[1] = req_origin_y; o[2] = req_origin_z;
            d[0] = req_dir_x; d[1] = req_dir_y; d[2] = req_dir_z;
            h[0] = req_half_x; h[1] = req_half_y; h[2] = req_half_z;
            hit_queue = {hit_queue, slab_test(o, d, h)};
         end
         if (rsp_valid && !rsp_stall) begin
            if (hit_queue.size() == 0) begin
               $display("%0t: unexpected result transfer hit=%0b param=%0d",
                        $time, rsp_hit, rsp_ray_param);
               fail_count <= fail_count + 1;
            end else begin
               want = hit_queue.pop_front();
               if (rsp_hit) hit_count <= hit_count + 1;
               if (want.hit !== rsp_hit || want.ray_param !== rsp_ray_param) begin
                  $display("%0t: expected hit=%0b param=%0d, actual hit=%0b param=%0d",
                           $time, want.hit, want.ray_param, rsp_hit, rsp_ray_param);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/ray_box_slab_intersect_test.sv -----
// Top of the ray versus box testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module ray_box_slab_intersect_test;

   localparam int LATENCY = 55;
   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_origin_x, req_origin_y, req_origin_z;
   logic signed [31:0] req_dir_x, req_dir_y, req_dir_z;
   logic        [30:0] req_half_x, req_half_y, req_half_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_hit;
   logic signed [31:0] rsp_ray_param;
   int                 fail_count;
   int                 pending_count;
   int                 hit_count;
   int                 send_idle_pct;
   int                 stall_pct;
   int                 idle_cycles;
   int                 ray_count;

   ray_box_slab_intersect u_top (.*);

   ray_box_slab_intersect_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Random coordinate mixing extremes, small values and full-range noise.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3, 4: return 32'($signed($urandom_range(2 * 262144)) - 262144);
         5: return 32'($signed($urandom_range(2048)) - 1024);
         default: return $urandom();
      endcase
   endfunction

   // Half extent, mostly moderate so that many rays hit.
   function automatic logic [30:0] pick_half();
      case ($urandom_range(7))
         0: return 31'h7FFF_FFFF;
         1: return 31'd0;
         2: return 31'($urandom());
         default: return 31'($urandom_range(8 * 65536));
      endcase
   endfunction

   // Offer one ray and hold it until the block takes it.
   task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [30:0] hx, logic [30:0] hy, logic [30:0] hz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_origin_x <= ox; req_origin_y <= oy; req_origin_z <= oz;
      req_dir_x <= dx; req_dir_y <= dy; req_dir_z <= dz;
      req_half_x <= hx; req_half_y <= hy; req_half_z <= hz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ray_count++;
   endtask

   task automatic send_random_ray();
      // A third of the rays aim from their origin toward the box center.
      logic [31:0] ox, oy, oz;
      ox = pick_coord(); oy = pick_coord(); oz = pick_coord();
      if ($urandom_range(2) == 0)
         send_ray(ox, oy, oz, -ox, -oy, -oz, pick_half(), pick_half(), pick_half());
      else
         send_ray(ox, oy, oz, pick_coord(), pick_coord(), pick_coord(),
                  pick_half(), pick_half(), pick_half());
   endtask

   initial begin
      int lim;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      ray_count = 0;
      {req_origin_x, req_origin_y, req_origin_z} = '0;
      {req_dir_x, req_dir_y, req_dir_z} = '0;
      {req_half_x, req_half_y, req_half_z} = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed rays: hits from outside and inside, parallel axes, extremes.
      send_ray(-32'sd5 <<< 16, 0, 0, 32'sd1 <<< 16, 0, 0, 31'd65536, 31'd65536, 31'd65536);
      send_ray(0, 0, 0, 32'sd1 <<< 16, 0, 0, 31'd65536, 31'd65536, 31'd65536);
      send_ray(0, 0, 0, 0, 0, 0, 31'd65536, 31'd65536, 31'd65536);
      send_ray(0, 32'sd3 <<< 16, 0, 32'sd1 <<< 16, 0, 0, 31'd65536, 31'd65536, 31'd65536);
      send_ray(32'sd5 <<< 16, 0, 0, 32'sd1 <<< 16, 0, 0, 31'd65536, 31'd65536, 31'd65536);
      send_ray(32'h8000_0000, 0, 0, 32'sd1, 0, 0, 31'h7FFF_FFFF, 31'd65536, 31'd65536);
      send_ray(32'h7FFF_FFFF, 0, 0, -32'sd1, 0, 0, 31'd1, 31'd65536, 31'd65536);
      send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0, 31'd0);
      send_ray(-32'sd2 <<< 16, -32'sd2 <<< 16, 0, 32'sd1 <<< 16, -32'sd1 <<< 16, 0,
               31'd65536, 31'd65536, 31'd65536);
      send_ray(-32'sd1 <<< 16, 0, 0, 32'sd3, 32'sd7, -32'sd5, 31'd65536, 31'd65536, 31'd65536);
      send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd0, 31'd0, 31'd0);
      send_ray(32'h5555_5555, 32'hAAAA_AAAA, 0, 32'hAAAA_AAAA, 32'h5555_5555, 32'd1,
               31'h5555_5555, 31'h2AAA_AAAA, 31'd0);

      // Random rays over the idling phases, 500 each.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 64; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 64; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         for (int i = 0; i < 500; i++) send_random_ray();
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      lim = 0;
      while (pending_count != 0 && lim < WATCHDOG_LIMIT) begin
         @(posedge clock);
         lim++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d rays over four idling phases; %0d results were hits.",
               ray_count, hit_count);
      if (fail_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
